FILE: rtl/crc8_command_framer_core_assert.svh
// assertion macros shared by the command framer modules
`ifndef CRC8_COMMAND_FRAMER_CORE_ASSERT_SVH
`define CRC8_COMMAND_FRAMER_CORE_ASSERT_SVH

// checked on every clock edge outside reset
`define CF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("framer check failed");

// checked on every clock edge, reset included
`define CF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("framer check failed");

`endif

FILE: rtl/crc8cf_pkg.sv
// shared types, constants and crc function of the command framer
package crc8cf_pkg;

    localparam logic [7:0] HdrFirst   = 8'h51;
    localparam logic [7:0] HdrSecond  = 8'hAC;
    localparam logic [7:0] LenExtra   = 8'd2;
    localparam logic [7:0] MaxPayload = 8'd253;
    localparam logic [7:0] CrcInit    = 8'h01;
    localparam logic [7:0] CrcPoly    = 8'h8C;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);
    localparam int StepW  = 3;

    localparam logic [StepW-1:0] StepHdr2 = 3'd1;
    localparam logic [StepW-1:0] StepLen  = 3'd2;
    localparam logic [StepW-1:0] StepCmd  = 3'd3;
    localparam logic [StepW-1:0] StepCrc  = 3'd4;

    typedef enum logic [1:0] {
        K_START   = 2'd0,
        K_PAYLOAD = 2'd1,
        K_ERROR   = 2'd2
    } t_kind;

    // one classified transaction, waiting for the back end
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;      // command id or payload byte
        logic [7:0] len_byte;  // length byte of a start
        logic [7:0] crc;       // crc after this byte
        logic       close;     // crc byte follows
    } t_cmd;

    // reflected crc-8 update, bitwise over the eight bits of (crc ^ byte)
    function automatic logic [7:0] f_crc8(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/crc8cf_if.sv
// channel interfaces of the command framer
interface crc8cf_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] command_id;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;

    modport source (output valid, operation, command_id, payload_length, payload_byte,
                    input ready);
    modport sink   (input valid, operation, command_id, payload_length, payload_byte,
                    output ready);
endinterface

interface crc8cf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       status;

    modport source (output valid, frame_byte, end_of_frame, status, input ready);
    modport sink   (input valid, frame_byte, end_of_frame, status, output ready);
endinterface

FILE: rtl/crc8_command_framer_core.sv
// top level of the crc-8 command framer
//
//   channel | dir | transaction
//   i_in    | in  | start (command id, length) or one payload byte
//   o_out   | out | one frame byte with end-of-frame and status flags
//
// output runs at one byte per cycle unless o_out stalls; a start expands to
// 4 or 5 output bytes, a payload byte to 1 or 2, an error byte to 1
// input is taken every cycle while the 4-entry queue has room, so the
// sustained input rate is set by the output byte count of each transaction
// reset is synchronous, active low, and empties the queue and frame state
// a stall on o_out backs up into the queue, then drops i_in.ready
module crc8_command_framer_core
    import crc8cf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    crc8cf_in_if.sink     i_in,
    crc8cf_out_if.source  o_out
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    crc8cf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    crc8cf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    crc8cf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/crc8cf_front.sv
// front end: accepts transactions, tracks frame state and crc, classifies
`include "crc8_command_framer_core_assert.svh"
module crc8cf_front
    import crc8cf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    crc8cf_in_if.sink    i_in,
    input  logic         i_q_full,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic [7:0] r_crc, n_crc;
    logic [7:0] r_rem, n_rem;
    logic       r_open, n_open;
    logic [7:0] len_sat;
    logic [7:0] crc_upd;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign len_sat    = (i_in.payload_length > MaxPayload) ? MaxPayload : i_in.payload_length;

    always_comb begin
        n_crc         = r_crc;
        n_rem         = r_rem;
        n_open        = r_open;
        crc_upd       = 8'h00;
        o_cmd.kind    = K_ERROR;
        o_cmd.data    = i_in.payload_byte;
        o_cmd.len_byte = len_sat + LenExtra;
        o_cmd.crc     = 8'h00;
        o_cmd.close   = 1'b0;
        if (!i_in.operation) begin
            crc_upd     = f_crc8(CrcInit, i_in.command_id);
            o_cmd.kind  = K_START;
            o_cmd.data  = i_in.command_id;
            o_cmd.crc   = crc_upd;
            o_cmd.close = (len_sat == 8'd0);
            if (len_sat == 8'd0) begin
                n_crc  = CrcInit;
                n_rem  = 8'd0;
                n_open = 1'b0;
            end else begin
                n_crc  = crc_upd;
                n_rem  = len_sat;
                n_open = 1'b1;
            end
        end else if (r_open) begin
            crc_upd     = f_crc8(r_crc, i_in.payload_byte);
            o_cmd.kind  = K_PAYLOAD;
            o_cmd.crc   = crc_upd;
            o_cmd.close = (r_rem == 8'd1);
            n_rem       = r_rem - 8'd1;
            if (r_rem == 8'd1) begin
                n_crc  = CrcInit;
                n_open = 1'b0;
            end else begin
                n_crc  = crc_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CrcInit;
            r_rem  <= 8'd0;
            r_open <= 1'b0;
        end else if (o_push) begin
            r_crc  <= n_crc;
            r_rem  <= n_rem;
            r_open <= n_open;
        end
    end

    // a closed frame always sits at the reset state
    `CF_ASSERT(a_closed_idle, i_clk, i_rst_n, !r_open |-> (r_rem == 8'd0 && r_crc == CrcInit))
    // an open frame still owes at least one payload byte
    `CF_ASSERT(a_open_rem, i_clk, i_rst_n, r_open |-> (r_rem != 8'd0 && r_rem <= MaxPayload))

endmodule

FILE: rtl/crc8cf_queue.sv
// short fifo of classified transactions between front and back ends
`include "crc8_command_framer_core_assert.svh"
module crc8cf_queue
    import crc8cf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCntW'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `CF_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `CF_ASSERT(a_ptr_count, i_clk, i_rst_n, (r_wr - r_rd) == r_cnt[QPtrW-1:0])

endmodule

FILE: rtl/crc8cf_back.sv
// back end: expands each queued transaction into output bytes
`include "crc8_command_framer_core_assert.svh"
module crc8cf_back
    import crc8cf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_head,
    output logic          o_pop,
    crc8cf_out_if.source  o_out
);

    logic [StepW-1:0] r_step;
    logic             r_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_eof, n_eof;
    logic             r_status, n_status;
    logic             last;
    logic             advance;
    logic             emit;

    assign advance = !r_valid || o_out.ready;
    assign emit    = advance && i_q_valid;
    assign o_pop   = emit && last;

    assign o_out.valid        = r_valid;
    assign o_out.frame_byte   = r_byte;
    assign o_out.end_of_frame = r_eof;
    assign o_out.status       = r_status;

    always_comb begin
        n_byte   = 8'h00;
        n_eof    = 1'b0;
        n_status = 1'b0;
        last     = 1'b1;
        unique case (i_head.kind)
            K_START: begin
                priority if (r_step == '0) begin
                    n_byte = HdrFirst;
                    last   = 1'b0;
                end else if (r_step == StepHdr2) begin
                    n_byte = HdrSecond;
                    last   = 1'b0;
                end else if (r_step == StepLen) begin
                    n_byte = i_head.len_byte;
                    last   = 1'b0;
                end else if (r_step == StepCmd) begin
                    n_byte = i_head.data;
                    last   = !i_head.close;
                end else begin
                    n_byte = i_head.crc;
                    n_eof  = 1'b1;
                end
            end
            K_PAYLOAD: begin
                if (r_step == '0) begin
                    n_byte = i_head.data;
                    last   = !i_head.close;
                end else begin
                    n_byte = i_head.crc;
                    n_eof  = 1'b1;
                end
            end
            K_ERROR: begin
                n_status = 1'b1;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (advance) begin
                r_valid <= i_q_valid;
            end
            if (emit) begin
                r_step <= last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte   <= n_byte;
            r_eof    <= n_eof;
            r_status <= n_status;
        end
    end

    `CF_ASSERT(a_step_range, i_clk, i_rst_n, r_step <= StepCrc)
    // a payload transaction never gets past its crc byte
    `CF_ASSERT(a_payload_steps, i_clk, i_rst_n,
        (i_q_valid && i_head.kind == K_PAYLOAD) |-> r_step <= StepHdr2)

endmodule
